@@ hw/rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Shared types, byte codes and error codes of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_SEP
  } kind_t;

  // One classified text byte. The code is 1 for parentheses, 2 for braces
  // and 3 for brackets.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  code;
    logic        last;
  } op_t;

  localparam logic [7:0] CHAR_LPAREN   = 8'h28;
  localparam logic [7:0] CHAR_RPAREN   = 8'h29;
  localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] SEP_RESET     = 8'h7C;

  localparam logic [1:0] CODE_NONE    = 2'd0;
  localparam logic [1:0] CODE_PAREN   = 2'd1;
  localparam logic [1:0] CODE_BRACE   = 2'd2;
  localparam logic [1:0] CODE_BRACKET = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNCLOSED = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  function automatic logic [7:0] opener_ascii(input logic [1:0] code);
    logic [7:0] res;
    case (code)
      CODE_PAREN:   res = CHAR_LPAREN;
      CODE_BRACE:   res = CHAR_LBRACE;
      CODE_BRACKET: res = CHAR_LBRACKET;
      default:      res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bbc_front.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker front end
// Classifies each incoming text word as opener, closer, line separator or
// other byte and hands it on toward the queue.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    char_in,
  input  logic          end_of_text,
  input  logic [7:0]    line_sep,
  output logic          op_valid,
  input  logic          op_ready,
  output bbc_pkg::op_t  op
);

  always_comb begin
    op.last = end_of_text;
    op.code = bbc_pkg::CODE_NONE;
    op.kind = bbc_pkg::KIND_OTHER;
    unique case (char_in)
      bbc_pkg::CHAR_LPAREN: begin
        op.kind = bbc_pkg::KIND_OPEN;
        op.code = bbc_pkg::CODE_PAREN;
      end
      bbc_pkg::CHAR_LBRACE: begin
        op.kind = bbc_pkg::KIND_OPEN;
        op.code = bbc_pkg::CODE_BRACE;
      end
      bbc_pkg::CHAR_LBRACKET: begin
        op.kind = bbc_pkg::KIND_OPEN;
        op.code = bbc_pkg::CODE_BRACKET;
      end
      bbc_pkg::CHAR_RPAREN: begin
        op.kind = bbc_pkg::KIND_CLOSE;
        op.code = bbc_pkg::CODE_PAREN;
      end
      bbc_pkg::CHAR_RBRACE: begin
        op.kind = bbc_pkg::KIND_CLOSE;
        op.code = bbc_pkg::CODE_BRACE;
      end
      bbc_pkg::CHAR_RBRACKET: begin
        op.kind = bbc_pkg::KIND_CLOSE;
        op.code = bbc_pkg::CODE_BRACKET;
      end
      default: begin
        if (char_in == line_sep) begin
          op.kind = bbc_pkg::KIND_SEP;
        end
      end
    endcase
  end

  assign op_valid = in_valid;
  assign in_ready = op_ready;

endmodule

@@ hw/rtl/bbc_queue.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker queue
// Two-entry queue of classified words between the front end and the stack
// engine.
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bbc_pkg::op_t  wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bbc_pkg::op_t  rd_op
);

  localparam logic [1:0] QUEUE_FULL = 2'd2;

  bbc_pkg::op_t entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;
  logic         push;
  logic         pop;

  assign wr_ready = (count_r != QUEUE_FULL);
  assign rd_valid = (count_r != 2'd0);
  assign rd_op    = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

@@ hw/rtl/bbc_back.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker stack engine
// Carries out pushes, pops and line counting on classified words and holds
// the result word in an output register.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  output logic          op_ready,
  input  bbc_pkg::op_t  op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_finished,
  output logic          out_balanced,
  output logic [2:0]    out_error_code,
  output logic [15:0]   out_line_number,
  output logic [7:0]    out_top_opener
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);
  localparam logic [FW-1:0] FILL_ZERO = '0;

  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [1:0]    top_r;
  logic [1:0]    top_nxt;
  logic [15:0]   line_r;
  logic [15:0]   line_nxt;
  logic [2:0]    err_r;
  logic [2:0]    err_nxt;

  logic [FW-1:0] fill_op;
  logic [1:0]    top_op;
  logic [15:0]   line_op;
  logic [2:0]    err_op;
  logic          had_err;
  logic          take;
  logic          push_en;
  logic          fin;
  logic [1:0]    below_top;
  logic [FW-1:0] raddr_full;

  logic          out_valid_r;
  logic          fin_r;
  logic          bal_r;
  logic [2:0]    code_r;
  logic [15:0]   line_out_r;
  logic [7:0]    top_out_r;

  assign op_ready = !out_valid_r || out_ready;
  assign take     = op_valid && op_ready;
  assign had_err  = (err_r != bbc_pkg::ERR_NONE);

  always_comb begin
    fill_op = fill_r;
    top_op  = top_r;
    line_op = line_r;
    err_op  = err_r;
    push_en = 1'b0;
    if (!had_err) begin
      unique case (op.kind)
        bbc_pkg::KIND_OPEN: begin
          if (fill_r == FILL_FULL) begin
            err_op = bbc_pkg::ERR_OVERFLOW;
          end else begin
            push_en = take;
            fill_op = fill_r + FW'(1);
            top_op  = op.code;
          end
        end
        bbc_pkg::KIND_CLOSE: begin
          if (fill_r == FILL_ZERO || top_r != op.code) begin
            err_op = {1'b0, op.code};
          end else begin
            fill_op = fill_r - FW'(1);
            top_op  = below_top;
          end
        end
        bbc_pkg::KIND_SEP: begin
          if (line_r != bbc_pkg::LINE_MAX) begin
            line_op = line_r + 16'd1;
          end
        end
        default: begin
        end
      endcase
      if (op.last && err_op == bbc_pkg::ERR_NONE && fill_op != FILL_ZERO) begin
        err_op = bbc_pkg::ERR_UNCLOSED;
      end
    end
    fin = op.last || (!had_err && err_op != bbc_pkg::ERR_NONE);
  end

  always_comb begin
    fill_nxt = fill_r;
    top_nxt  = top_r;
    line_nxt = line_r;
    err_nxt  = err_r;
    if (take) begin
      if (op.last) begin
        fill_nxt = FILL_ZERO;
        top_nxt  = bbc_pkg::CODE_NONE;
        line_nxt = bbc_pkg::LINE_FIRST;
        err_nxt  = bbc_pkg::ERR_NONE;
      end else begin
        fill_nxt = fill_op;
        top_nxt  = top_op;
        line_nxt = line_op;
        err_nxt  = err_op;
      end
    end
  end

  // The entry just below the top is fetched ahead, addressed from the next fill count.
  assign raddr_full = fill_nxt - FW'(2);

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (fill_r[AW-1:0]),
    .wdata (op.code),
    .raddr (raddr_full[AW-1:0]),
    .rdata (below_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= FILL_ZERO;
      top_r       <= bbc_pkg::CODE_NONE;
      line_r      <= bbc_pkg::LINE_FIRST;
      err_r       <= bbc_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      top_r  <= top_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fin_r      <= fin;
      bal_r      <= (err_op == bbc_pkg::ERR_NONE);
      code_r     <= err_op;
      line_out_r <= line_op;
      top_out_r  <= bbc_pkg::opener_ascii((fill_op == FILL_ZERO) ? bbc_pkg::CODE_NONE : top_op);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_finished    = fin_r;
  assign out_balanced    = bal_r;
  assign out_error_code  = code_r;
  assign out_line_number = line_out_r;
  assign out_top_opener  = top_out_r;

endmodule

@@ hw/rtl/bracket_balance_checker_top.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker
// Checks a byte stream for balanced brackets and reports one result word
// per input word with status, line number and the opener on the stack top.
// ----------------------------------------------------------------------------
// The block takes one text word per clock cycle while the output side is not
// stalled and returns one result word for each, held in a queue entry, then
// in the result register. The rate is set by the stack engine, which updates
// the stack top register, the fill count and the line counter once per cycle
// and uses one write and one registered read port of the stack memory. A
// two-entry queue separates the classifier from the stack engine; a new word
// enters the engine only while its result register is empty or being read.
// The stack, line count and error state clear after the end-of-text word.
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_finished,
  output logic        out_balanced,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_line_number,
  output logic [7:0]  out_top_opener
);

  logic [7:0]   line_sep_r;
  logic         front_valid;
  logic         front_ready;
  bbc_pkg::op_t front_op;
  logic         queue_valid;
  logic         queue_ready;
  bbc_pkg::op_t queue_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sep_r <= bbc_pkg::SEP_RESET;
    end else if (cfg_wr_en) begin
      line_sep_r <= cfg_wr_data;
    end
  end

  bbc_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_in     (in_char_in),
    .end_of_text (in_end_of_text),
    .line_sep    (line_sep_r),
    .op_valid    (front_valid),
    .op_ready    (front_ready),
    .op          (front_op)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_op    (front_op),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_op    (queue_op)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_valid        (queue_valid),
    .op_ready        (queue_ready),
    .op              (queue_op),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_finished    (out_finished),
    .out_balanced    (out_balanced),
    .out_error_code  (out_error_code),
    .out_line_number (out_line_number),
    .out_top_opener  (out_top_opener)
  );

endmodule
